### rtl/tpp_pkg.sv
package tpp_pkg;

  // Field widths of the pixel stream.
  localparam int X_W       = 10;
  localparam int Y_W       = 9;
  localparam int FRAME_W   = 64;
  localparam int CHAN_W    = 8;
  localparam int HASH_W    = 11;
  localparam int IN_DATA_W = 88;
  localparam int OUT_DATA_W = 24;

  // Pattern geometry.
  localparam int BAR_SHIFT     = 3;
  localparam int BAR_LEN       = 8;
  localparam int SAFE_X_MARGIN = 64;
  localparam int SAFE_Y_MARGIN = 44;
  localparam int BLUE_MOD      = 96;
  localparam int MOD96_W       = 7;

  // Colors.
  localparam logic [CHAN_W-1:0] ACCENT_BLUE_BASE = 8'd96;
  localparam logic [CHAN_W-1:0] GUIDE_R = 8'd36;
  localparam logic [CHAN_W-1:0] GUIDE_G = 8'd58;
  localparam logic [CHAN_W-1:0] GUIDE_B = 8'd78;
  localparam logic [CHAN_W-1:0] GRAD_R_BASE = 8'd12;
  localparam logic [CHAN_W-1:0] GRAD_G_BASE = 8'd18;
  localparam logic [CHAN_W-1:0] GRAD_B = 8'd34;
  localparam logic [CHAN_W-1:0] BG_R = 8'd6;
  localparam logic [CHAN_W-1:0] BG_G = 8'd8;
  localparam logic [CHAN_W-1:0] BG_B = 8'd14;

  // Red sits in the lowest bits of the output word.
  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb_t;

  // Per-pixel facts that do not depend on the frame residues.
  typedef struct packed {
    logic [X_W-1:0]    x;
    logic              guide;
    logic              safe;
    logic [CHAN_W-1:0] grad_r;
    logic [CHAN_W-1:0] grad_g;
    logic [CHAN_W-1:0] frame_lo;
  } side_t;

  // Load enables of the three residue stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

endpackage

### rtl/tpp_modred.sv
module tpp_modred import tpp_pkg::*; #(
  parameter int MOD = 640
) (
  input  logic                       clk_i,
  input  pipe_en_t                   en_i,
  input  logic [FRAME_W-1:0]         val_i,
  output logic [$clog2(MOD)-1:0]     res_o
);

  localparam int RES_W = $clog2(MOD);
  localparam int NIB   = FRAME_W / 4;
  localparam logic [RES_W:0] MOD_V = (RES_W+1)'(MOD);

  // Residue of n * 16**pos, built by doubling and adding with a conditional subtract.
  function automatic int nib_res(int pos, int n);
    int w;
    int acc;
    int i;
    int k;
    w = 1;
    for (i = 0; i < 4 * pos; i++) begin
      w = w * 2;
      if (w >= MOD) w = w - MOD;
    end
    acc = 0;
    for (k = 0; k < n; k++) begin
      acc = acc + w;
      if (acc >= MOD) acc = acc - MOD;
    end
    return acc;
  endfunction

  function automatic logic [RES_W-1:0] addm(logic [RES_W-1:0] a, logic [RES_W-1:0] b);
    logic [RES_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= MOD_V) s = s - MOD_V;
    return s[RES_W-1:0];
  endfunction

  logic [RES_W-1:0] tbl  [NIB][16];
  logic [RES_W-1:0] look [NIB];
  logic [RES_W-1:0] r1_q [8];
  logic [RES_W-1:0] r2_q [2];
  logic [RES_W-1:0] r3_q;

  for (genvar p = 0; p < NIB; p++) begin : g_tbl
    for (genvar n = 0; n < 16; n++) begin : g_ent
      assign tbl[p][n] = RES_W'(nib_res(p, n));
    end
    assign look[p] = tbl[p][val_i[4*p +: 4]];
  end

  for (genvar j = 0; j < 8; j++) begin : g_s1
    always_ff @(posedge clk_i) begin
      if (en_i.s1) r1_q[j] <= addm(look[2*j], look[2*j+1]);
    end
  end

  for (genvar j = 0; j < 2; j++) begin : g_s2
    always_ff @(posedge clk_i) begin
      if (en_i.s2) begin
        r2_q[j] <= addm(addm(r1_q[4*j], r1_q[4*j+1]), addm(r1_q[4*j+2], r1_q[4*j+3]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) r3_q <= addm(r2_q[0], r2_q[1]);
  end

  assign res_o = r3_q;

endmodule

### rtl/tpp_classify.sv
module tpp_classify import tpp_pkg::*; #(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  logic [X_W-1:0]    pixel_x_i,
  input  logic [Y_W-1:0]    pixel_y_i,
  input  logic [CHAN_W-1:0] frame_lo_i,
  output side_t             side_o
);

  localparam int CMP_W = 13;
  localparam logic [CMP_W-1:0] SafeXLo = CMP_W'(SAFE_X_MARGIN);
  localparam logic [CMP_W-1:0] SafeXHi = CMP_W'(FRAME_WIDTH - SAFE_X_MARGIN);
  localparam logic [CMP_W-1:0] SafeYLo = CMP_W'(SAFE_Y_MARGIN);
  localparam logic [CMP_W-1:0] SafeYHi = CMP_W'(FRAME_HEIGHT - SAFE_Y_MARGIN);

  function automatic logic mult15(logic [6:0] v);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < 9; k++) hit = hit | (v == 7'(15 * k));
    return hit;
  endfunction

  function automatic logic mult5(logic [4:0] v);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < 7; k++) hit = hit | (v == 5'(5 * k));
    return hit;
  endfunction

  logic [CMP_W-1:0] xe;
  logic [CMP_W-1:0] ye;

  assign xe = CMP_W'(pixel_x_i);
  assign ye = CMP_W'(pixel_y_i);

  always_comb begin
    side_o.x        = pixel_x_i;
    // A multiple of 120 is a multiple of 8 whose eighth is a multiple of 15;
    // a multiple of 80 is a multiple of 16 whose sixteenth is a multiple of 5.
    side_o.guide    = ((pixel_x_i[2:0] == 3'd0) && mult15(pixel_x_i[9:3])) ||
                      ((pixel_y_i[3:0] == 4'd0) && mult5(pixel_y_i[8:4]));
    side_o.safe     = (xe > SafeXLo) && (xe < SafeXHi) && (ye > SafeYLo) && (ye < SafeYHi);
    side_o.grad_r   = GRAD_R_BASE + CHAN_W'(pixel_x_i[9:5]);
    side_o.grad_g   = GRAD_G_BASE + CHAN_W'(pixel_y_i[8:5]);
    side_o.frame_lo = frame_lo_i;
  end

endmodule

### rtl/tpp_shade.sv
module tpp_shade import tpp_pkg::*; #(
  parameter int FRAME_WIDTH = 640
) (
  input  side_t                          side_i,
  input  logic [$clog2(FRAME_WIDTH)-1:0] bar_i,
  input  logic [MOD96_W-1:0]             mod96_i,
  input  logic [HASH_W-1:0]              accent_seed_i,
  output rgb_t                           rgb_o
);

  localparam int BAR_W = $clog2(FRAME_WIDTH);
  localparam int CW    = ((BAR_W > X_W) ? BAR_W : X_W) + 1;

  logic [CW-1:0] xe;
  logic [CW-1:0] bar_lo;
  logic [CW-1:0] bar_hi;
  logic          on_bar;

  assign xe     = CW'(side_i.x);
  assign bar_lo = CW'(bar_i);
  assign bar_hi = bar_lo + CW'(BAR_LEN);
  assign on_bar = (xe >= bar_lo) && (xe < bar_hi);

  always_comb begin
    if (on_bar) begin
      rgb_o.red   = accent_seed_i[CHAN_W-1:0] + side_i.frame_lo;
      rgb_o.green = accent_seed_i[HASH_W-1:HASH_W-CHAN_W];
      rgb_o.blue  = ACCENT_BLUE_BASE + CHAN_W'(mod96_i);
    end else if (side_i.guide) begin
      rgb_o.red   = GUIDE_R;
      rgb_o.green = GUIDE_G;
      rgb_o.blue  = GUIDE_B;
    end else if (side_i.safe) begin
      rgb_o.red   = side_i.grad_r;
      rgb_o.green = side_i.grad_g;
      rgb_o.blue  = GRAD_B;
    end else begin
      rgb_o.red   = BG_R;
      rgb_o.green = BG_G;
      rgb_o.blue  = BG_B;
    end
  end

endmodule

### rtl/placeholder_test_pattern_pixel_unit.sv
// Test pattern pixel generator: one pixel word in, one RGB word out, one pixel per
// clock sustained while the output side is ready. The pipeline is the three-stage
// residue tree that reduces the 64-bit frame count (frame / 8 mod FRAME_WIDTH for
// the moving bar, frame mod 96 for the bar's blue), followed by the output register
// that holds the selected color. Each stage stalls only when it is full and the
// stage after it is held, so bubbles close up and the input keeps flowing while a
// result waits. The accent seed is loaded through cfg_wr_en_i and is expected to
// change only while the pipeline is empty.
module placeholder_test_pattern_pixel_unit import tpp_pkg::*; #(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_wr_en_i,
  input  logic [HASH_W-1:0]     cfg_wr_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pixel_x [9:0], pixel_y [18:10], frame_number [82:19], zero fill [87:83]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int BAR_W = $clog2(FRAME_WIDTH);

  logic [X_W-1:0]     pixel_x;
  logic [Y_W-1:0]     pixel_y;
  logic [FRAME_W-1:0] frame_number;
  logic [FRAME_W-1:0] bar_count;

  logic [HASH_W-1:0] accent_seed_q;

  logic v1_q, v2_q, v3_q, out_valid_q;
  logic rdy1, rdy2, rdy3, rdy4;
  pipe_en_t en;

  side_t side0;
  side_t side1_q, side2_q, side3_q;
  logic [BAR_W-1:0]   bar;
  logic [MOD96_W-1:0] mod96;
  rgb_t rgb_d, rgb_q;

  assign pixel_x      = s_axis_tdata[9:0];
  assign pixel_y      = s_axis_tdata[18:10];
  assign frame_number = s_axis_tdata[82:19];
  assign bar_count    = frame_number >> BAR_SHIFT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accent_seed_q <= '0;
    end else if (cfg_wr_en_i) begin
      accent_seed_q <= cfg_wr_data_i;
    end
  end

  // A stage takes a new word when it is empty or its word moves on.
  assign rdy4 = !out_valid_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) out_valid_q <= v3_q;
    end
  end

  tpp_classify #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_classify (
    .pixel_x_i  (pixel_x),
    .pixel_y_i  (pixel_y),
    .frame_lo_i (frame_number[CHAN_W-1:0]),
    .side_o     (side0)
  );

  tpp_modred #(
    .MOD (FRAME_WIDTH)
  ) u_bar_mod (
    .clk_i (clk_i),
    .en_i  (en),
    .val_i (bar_count),
    .res_o (bar)
  );

  tpp_modred #(
    .MOD (BLUE_MOD)
  ) u_blue_mod (
    .clk_i (clk_i),
    .en_i  (en),
    .val_i (frame_number),
    .res_o (mod96)
  );

  always_ff @(posedge clk_i) begin
    if (rdy1) side1_q <= side0;
    if (rdy2) side2_q <= side1_q;
    if (rdy3) side3_q <= side2_q;
    if (rdy4) rgb_q   <= rgb_d;
  end

  tpp_shade #(
    .FRAME_WIDTH (FRAME_WIDTH)
  ) u_shade (
    .side_i        (side3_q),
    .bar_i         (bar),
    .mod96_i       (mod96),
    .accent_seed_i (accent_seed_q),
    .rgb_o         (rgb_d)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = rgb_q;

endmodule

### rtl/tpp_checker.sv
module tpp_checker import tpp_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic s_acc;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  // A held output word stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // With the output side ready, nothing in the pipeline can hold the input.
  a_no_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output side is ready");

  // With the output side ready, an accepted word reaches the output register.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(s_acc, 4) && $past(m_axis_tready, 3) && $past(m_axis_tready, 2) &&
    $past(m_axis_tready, 1) && $past(rst_ni, 3) && $past(rst_ni, 2) &&
    $past(rst_ni, 1) |-> m_axis_tvalid)
    else $error("pixel word lost in the pipeline");

endmodule

bind placeholder_test_pattern_pixel_unit tpp_checker u_tpp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tpp_pkg::*;

  localparam int FRAME_COLS  = 640;
  localparam int FRAME_ROWS  = 480;
  localparam int GUIDE_COLS  = 120;
  localparam int GUIDE_ROWS  = 80;
  localparam int GRAD_STEP   = 32;
  localparam int BAR_PERIOD  = FRAME_COLS * BAR_LEN;
  localparam int FILL_W      = IN_DATA_W - X_W - Y_W - FRAME_W;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 288;
  localparam int NUM_ROWS    = 24;

  typedef struct {
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
    logic [FRAME_W-1:0] frame;
    bit                 typed;
    logic [CHAN_W-1:0]  r;
    logic [CHAN_W-1:0]  g;
    logic [CHAN_W-1:0]  b;
  } pixel_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_wr_en_i;
  logic [HASH_W-1:0]     cfg_wr_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // pixel_x [9:0], pixel_y [18:10], frame_number [82:19], zero fill [87:83]
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // red [7:0], green [15:8], blue [23:16]
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  logic [HASH_W-1:0] accent_seed_model;
  rgb_t              pending_colors[$];
  int                src_idle_pct;
  int                sink_idle_pct;
  int                fail_count;
  pixel_row_t        directed_rows[NUM_ROWS];

  placeholder_test_pattern_pixel_unit #(
    .FRAME_WIDTH  (FRAME_COLS),
    .FRAME_HEIGHT (FRAME_ROWS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_wr_en_i   = 1'b0;
    cfg_wr_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
  end

  always #6 clk_i = ~clk_i;

  function automatic rgb_t pattern_color(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                                         input logic [FRAME_W-1:0] frame);
    logic [FRAME_W-1:0] bar_start;
    logic [FRAME_W-1:0] px;
    rgb_t               color;
    bar_start = (frame >> BAR_SHIFT) % FRAME_W'(FRAME_COLS);
    px        = FRAME_W'(x);
    if (px >= bar_start && px < bar_start + BAR_LEN) begin
      color.red   = CHAN_W'(FRAME_W'(accent_seed_model) + frame);
      color.green = CHAN_W'(accent_seed_model >> 3);
      color.blue  = ACCENT_BLUE_BASE + CHAN_W'(frame % FRAME_W'(BLUE_MOD));
    end else if (x % GUIDE_COLS == 0 || y % GUIDE_ROWS == 0) begin
      color = '{blue: GUIDE_B, green: GUIDE_G, red: GUIDE_R};
    end else if (x > SAFE_X_MARGIN && x < FRAME_COLS - SAFE_X_MARGIN &&
                 y > SAFE_Y_MARGIN && y < FRAME_ROWS - SAFE_Y_MARGIN) begin
      color.red   = GRAD_R_BASE + CHAN_W'(x / GRAD_STEP);
      color.green = GRAD_G_BASE + CHAN_W'(y / GRAD_STEP);
      color.blue  = GRAD_B;
    end else begin
      color = '{blue: BG_B, green: BG_G, red: BG_R};
    end
    return color;
  endfunction

  // The receiver's ready is redrawn every cycle; results are checked at the rising edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    rgb_t want;
    rgb_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_colors.size() == 0) begin
        fail_count++;
        $error("pixel word with no expected color: %h", got);
      end else begin
        want = pending_colors.pop_front();
        if (got.red !== want.red) begin
          fail_count++;
          $error("red: expected %0d, actual %0d", want.red, got.red);
        end
        if (got.green !== want.green) begin
          fail_count++;
          $error("green: expected %0d, actual %0d", want.green, got.green);
        end
        if (got.blue !== want.blue) begin
          fail_count++;
          $error("blue: expected %0d, actual %0d", want.blue, got.blue);
        end
      end
    end
  end

  task automatic send_pixel(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                            input logic [FRAME_W-1:0] frame, input bit typed,
                            input rgb_t typed_color);
    bit placed;
    placed = 1'b0;
    while (!placed) begin
      @(negedge clk_i);
      if ($urandom_range(0, 99) < src_idle_pct) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{FILL_W{1'b0}}, frame, y, x};
        placed = 1'b1;
      end
    end
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_colors.push_back(typed ? typed_color : pattern_color(x, y, frame));
  endtask

  task automatic drain_pipeline();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_accent_seed(input logic [HASH_W-1:0] value);
    drain_pipeline();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
    accent_seed_model = value;
  endtask

  initial begin
    int                 src_pcts[PHASES];
    int                 sink_pcts[PHASES];
    int                 pick;
    int                 bar_col;
    logic [X_W-1:0]     xr;
    logic [Y_W-1:0]     yr;
    logic [FRAME_W-1:0] fr;
    logic [FRAME_W-1:0] periods;

    src_pcts  = '{38, 38, 52, 52, 0, 0};
    sink_pcts = '{52, 52, 38, 38, 0, 0};
    fail_count        = 0;
    accent_seed_model = '0;
    src_idle_pct      = src_pcts[0];
    sink_idle_pct     = sink_pcts[0];

    // Frame 4800 puts the bar at columns 600 to 607, frame 5112 at the last column,
    // where it runs past the right edge instead of wrapping to the left.
    directed_rows = '{
      '{10'd1,    9'd1,   64'd4800, 1'b1, BG_R,    BG_G,    BG_B},
      '{10'd0,    9'd1,   64'd4800, 1'b1, GUIDE_R, GUIDE_G, GUIDE_B},
      '{10'd1,    9'd0,   64'd4800, 1'b1, GUIDE_R, GUIDE_G, GUIDE_B},
      '{10'd120,  9'd1,   64'd4800, 1'b1, GUIDE_R, GUIDE_G, GUIDE_B},
      '{10'd1,    9'd80,  64'd4800, 1'b1, GUIDE_R, GUIDE_G, GUIDE_B},
      '{10'd100,  9'd100, 64'd4800, 1'b1, 8'd15,   8'd21,   GRAD_B},
      '{10'd1023, 9'd511, 64'd4800, 1'b1, BG_R,    BG_G,    BG_B},
      '{10'd0,    9'd0,   64'd0,    1'b1, 8'd0,    8'd0,    ACCENT_BLUE_BASE},
      '{10'd7,    9'd1,   64'd0,    1'b1, 8'd0,    8'd0,    ACCENT_BLUE_BASE},
      '{10'd8,    9'd1,   64'd0,    1'b1, BG_R,    BG_G,    BG_B},
      '{10'd639,  9'd100, 64'd5112, 1'b0, 8'd0, 8'd0, 8'd0},
      '{10'd646,  9'd100, 64'd5112, 1'b0, 8'd0, 8'd0, 8'd0},
      '{10'd647,  9'd100, 64'd5112, 1'b0, 8'd0, 8'd0, 8'd0},
      '{10'd3,    9'd100, 64'd5112, 1'b0, 8'd0, 8'd0, 8'd0},
      '{10'd64,   9'd100, 64'd4800, 1'b0, 8'd0, 8'd0, 8'd0},
      '{10'd65,   9'd100, 64'd4800, 1'b0, 8'd0, 8'd0, 8'd0},
      '{10'd575,  9'd435, 64'd4800, 1'b0, 8'd0, 8'd0, 8'd0},
      '{10'd576,  9'd436, 64'd4800, 1'b0, 8'd0, 8'd0, 8'd0},
      '{10'd300,  9'd44,  64'd4800, 1'b0, 8'd0, 8'd0, 8'd0},
      '{10'd300,  9'd45,  64'd4800, 1'b0, 8'd0, 8'd0, 8'd0},
      '{10'd512,  9'd256, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'd0, 8'd0, 8'd0},
      '{10'd960,  9'd479, 64'h8000_0000_0000_0007, 1'b0, 8'd0, 8'd0, 8'd0},
      '{10'd700,  9'd300, 64'd5600, 1'b0, 8'd0, 8'd0, 8'd0},
      '{10'd1023, 9'd511, 64'd5112, 1'b0, 8'd0, 8'd0, 8'd0}
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i].x, directed_rows[i].y, directed_rows[i].frame,
                 directed_rows[i].typed,
                 '{blue: directed_rows[i].b, green: directed_rows[i].g,
                   red: directed_rows[i].r});
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        case (p)
          1, 4:    write_accent_seed('1);
          3:       write_accent_seed('0);
          default: write_accent_seed(HASH_W'($urandom_range(1, (1 << HASH_W) - 2)));
        endcase
      end
      src_idle_pct  = src_pcts[p];
      sink_idle_pct = sink_pcts[p];

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == PHASE_ITEMS / 2) drain_pipeline();

        pick = $urandom_range(0, 99);
        if (pick < 75)      xr = X_W'($urandom_range(0, FRAME_COLS - 1));
        else if (pick < 88) xr = X_W'($urandom_range(FRAME_COLS, (1 << X_W) - 1));
        else                xr = X_W'(GUIDE_COLS * $urandom_range(0, 8));
        pick = $urandom_range(0, 99);
        if (pick < 75)      yr = Y_W'($urandom_range(0, FRAME_ROWS - 1));
        else if (pick < 88) yr = Y_W'($urandom_range(FRAME_ROWS, (1 << Y_W) - 1));
        else                yr = Y_W'(GUIDE_ROWS * $urandom_range(0, 6));

        // Close to half of the frames place the bar at or just left of the pixel so that it gets hit often.
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          fr = {$urandom, $urandom};
        end else if (pick < 80) begin
          bar_col = int'(xr) - $urandom_range(0, 9);
          if (bar_col < 0) bar_col = 0;
          if (bar_col > FRAME_COLS - 1) bar_col = FRAME_COLS - 1 - $urandom_range(0, 3);
          if ($urandom_range(0, 1) == 0) periods = {$urandom, $urandom} >> 14;
          else                           periods = FRAME_W'($urandom_range(0, 50));
          fr = periods * BAR_PERIOD + FRAME_W'(bar_col * BAR_LEN) +
               FRAME_W'($urandom_range(0, BAR_LEN - 1));
        end else begin
          fr = FRAME_W'($urandom_range(0, 20000));
        end

        send_pixel(xr, yr, fr, 1'b0, '0);
      end
    end

    drain_pipeline();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/tpp_pkg.sv
rtl/tpp_modred.sv
rtl/tpp_classify.sv
rtl/tpp_shade.sv
rtl/placeholder_test_pattern_pixel_unit.sv
rtl/tpp_checker.sv
tb/testbench.sv
